// File: hdl/mvcc_pkg.sv
// ----------------------------------------------------------------------------
// mvcc_pkg
// Shared widths and types for the version chain block.
// ----------------------------------------------------------------------------
package mvcc_pkg;

    localparam int HIST_DEPTH   = 10;
    localparam int PAYLOAD_BITS = 32;
    localparam int TXN_W        = 64;
    localparam int HANDLE_W     = 32;
    localparam int CNT_W        = 4;
    localparam int FILL_W       = $clog2(HIST_DEPTH + 1);

    // Mode codes of an input item
    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_READ = 1'b1;

    // One stored version
    typedef struct packed {
        logic [TXN_W-1:0]        commit;
        logic                    tomb;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_entry;

    // Search result rippling down the chain, newest first
    typedef struct packed {
        logic                    hit;
        logic                    tomb;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_hit;

    // Per-cell control from the top level
    typedef struct packed {
        logic cmp;
        logic live;
        logic shift;
        logic put;
    } t_cell_ctl;

endpackage

// File: hdl/mvcc_in_if.sv
// ----------------------------------------------------------------------------
// mvcc_in_if
// Input channel: valid/ready handshake with one add or read item.
// ----------------------------------------------------------------------------
interface mvcc_in_if;
    import mvcc_pkg::*;

    logic              valid;
    logic              ready;
    logic              mode;
    logic [TXN_W-1:0]  reader_txn;
    logic [TXN_W-1:0]  new_commit_txn;
    logic              new_tombstone;
    logic              new_has_key;
    logic [31:0]       new_payload;

    modport source (
        output valid, mode, reader_txn, new_commit_txn, new_tombstone,
               new_has_key, new_payload,
        input  ready
    );

    modport sink (
        input  valid, mode, reader_txn, new_commit_txn, new_tombstone,
               new_has_key, new_payload,
        output ready
    );

endinterface

// File: hdl/mvcc_out_if.sv
// ----------------------------------------------------------------------------
// mvcc_out_if
// Output channel: valid/ready handshake with one result item.
// ----------------------------------------------------------------------------
interface mvcc_out_if;
    import mvcc_pkg::*;

    logic                valid;
    logic                ready;
    logic                found;
    logic                hit_tombstone;
    logic [HANDLE_W-1:0] value_handle;
    logic [CNT_W-1:0]    history_count;

    modport source (
        output valid, found, hit_tombstone, value_handle, history_count,
        input  ready
    );

    modport sink (
        input  valid, found, hit_tombstone, value_handle, history_count,
        output ready
    );

endinterface

// File: hdl/mvcc_cell.sv
// ----------------------------------------------------------------------------
// mvcc_cell
// One history slot: holds a version, shifts toward older slots when the
// history is full, flags visibility for a reader and passes the newest hit
// down the chain.
// ----------------------------------------------------------------------------
module mvcc_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  mvcc_pkg::t_cell_ctl        i_ctl,
    input  logic [mvcc_pkg::TXN_W-1:0] i_reader,
    input  mvcc_pkg::t_entry           i_next,
    input  mvcc_pkg::t_entry           i_cur,
    input  mvcc_pkg::t_hit             i_up,
    output mvcc_pkg::t_entry           o_entry,
    output mvcc_pkg::t_hit             o_dn
);
    import mvcc_pkg::*;

    t_entry r_ent;
    logic   r_match;

    // Load on shift (from newer neighbor) or on push into this slot
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_ent <= i_next;
        end else if (i_ctl.put) begin
            r_ent <= i_cur;
        end
    end

    // Flag visibility for the reader
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_ctl.cmp) begin
            r_match <= i_ctl.live && (r_ent.commit != '0) && (r_ent.commit < i_reader);
        end
    end

    // Pass a newer hit through, else offer this slot
    always_comb begin
        if (i_up.hit) begin
            o_dn = i_up;
        end else begin
            o_dn.hit     = r_match;
            o_dn.tomb    = r_ent.tomb;
            o_dn.payload = r_ent.payload;
        end
    end

    assign o_entry = r_ent;

endmodule

// File: hdl/mvcc_version_chain_top.sv
// ----------------------------------------------------------------------------
// mvcc_version_chain_top
// Version chain of one key: current version plus a bounded history.
// ----------------------------------------------------------------------------
// Each item runs through a compare step and a result step: in the compare
// step every history cell compares its commit id with the reader's id (or,
// for an add, the chain shifts or loads one slot), in the result step the hit
// ripples from the newest cell to the oldest and the result is registered. A
// new item is taken in the same cycle that a result is registered, as long as
// the output is drained; a stalled output holds one result and lets the next
// item be accepted. History slots hold no reset value; only slots below the
// fill count are ever searched.
module mvcc_version_chain_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mvcc_in_if.sink    i_in,
    mvcc_out_if.source o_out
);
    import mvcc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state                r_state, n_state;
    logic                  r_mode;
    logic [TXN_W-1:0]      r_reader;
    t_entry                r_new;
    logic                  r_new_key;
    t_entry                r_cur;
    logic                  r_cur_key;
    logic                  r_cur_vis;
    logic [FILL_W-1:0]     r_fill;
    logic                  r_out_valid;
    logic                  r_found;
    logic                  r_tomb;
    logic [HANDLE_W-1:0]   r_handle;
    logic [CNT_W-1:0]      r_count;

    logic                  w_accept;
    logic                  w_out_free;
    logic                  w_load_out;
    logic                  w_add;
    logic                  w_push;
    logic                  w_full;
    t_entry                w_ent [HIST_DEPTH];
    t_hit                  w_dn  [HIST_DEPTH];
    t_cell_ctl             w_ctl [HIST_DEPTH];
    t_hit                  w_top_hit;
    t_hit                  w_res;

    // Handshake
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_load_out = (r_state == S_DONE) && w_out_free;
    assign i_in.ready = (r_state == S_IDLE) || w_load_out;
    assign w_accept   = i_in.valid && i_in.ready;

    // Add control
    assign w_add  = (r_state == S_CMP) && (r_mode == MODE_ADD);
    assign w_push = w_add && (r_cur_key || (r_cur.commit != '0) || (r_fill != '0));
    assign w_full = (r_fill == FILL_W'(HIST_DEPTH));

    // Sequence an item
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (w_accept) n_state = S_CMP;
            S_CMP:  n_state = S_DONE;
            S_DONE: begin
                if (w_load_out) n_state = w_accept ? S_CMP : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the item
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode        <= i_in.mode;
            r_reader      <= i_in.reader_txn;
            r_new.commit  <= i_in.new_commit_txn;
            r_new.tomb    <= i_in.new_tombstone;
            r_new.payload <= PAYLOAD_BITS'(i_in.new_payload);
            r_new_key     <= i_in.new_has_key;
        end
    end

    // Current version and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur     <= '0;
            r_cur_key <= 1'b0;
            r_fill    <= '0;
            r_cur_vis <= 1'b0;
        end else if (r_state == S_CMP) begin
            if (w_add) begin
                r_cur     <= r_new;
                r_cur_key <= r_new_key;
                if (w_push && !w_full) begin
                    r_fill <= r_fill + FILL_W'(1);
                end
            end else begin
                r_cur_vis <= (r_cur.commit != '0) && (r_cur.commit < r_reader);
            end
        end
    end

    // Chain of history cells, newest slot at the top
    assign w_top_hit.hit     = r_cur_vis;
    assign w_top_hit.tomb    = r_cur.tomb;
    assign w_top_hit.payload = r_cur.payload;

    for (genvar i = 0; i < HIST_DEPTH; i++) begin : g_cell
        t_entry w_next;
        t_hit   w_up;

        assign w_ctl[i].cmp   = (r_state == S_CMP) && (r_mode == MODE_READ);
        assign w_ctl[i].live  = r_fill > FILL_W'(i);
        assign w_ctl[i].shift = w_push && w_full;
        assign w_ctl[i].put   = w_push && !w_full && (r_fill == FILL_W'(i));

        if (i == HIST_DEPTH - 1) begin : g_top
            assign w_next = r_cur;
            assign w_up   = w_top_hit;
        end else begin : g_mid
            assign w_next = w_ent[i+1];
            assign w_up   = w_dn[i+1];
        end

        mvcc_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl[i]),
            .i_reader (r_reader),
            .i_next   (w_next),
            .i_cur    (r_cur),
            .i_up     (w_up),
            .o_entry  (w_ent[i]),
            .o_dn     (w_dn[i])
        );
    end

    assign w_res = w_dn[0];

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_count <= CNT_W'(r_fill);
            if (r_mode == MODE_READ && w_res.hit) begin
                r_found  <= !w_res.tomb;
                r_tomb   <= w_res.tomb;
                r_handle <= w_res.tomb ? '0 : HANDLE_W'(w_res.payload);
            end else begin
                r_found  <= 1'b0;
                r_tomb   <= 1'b0;
                r_handle <= '0;
            end
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.found         = r_found;
    assign o_out.hit_tombstone = r_tomb;
    assign o_out.value_handle  = r_handle;
    assign o_out.history_count = r_count;

    // Checks
    a_cmp_then_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CMP |=> r_state == S_DONE)
        else $error("compare step not followed by result step");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(HIST_DEPTH))
        else $error("history fill beyond depth");

    a_found_xor_tomb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_found && r_tomb))
        else $error("result both found and tombstone");

    a_handle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_found) |-> (r_handle == '0))
        else $error("handle nonzero without a hit");

endmodule
